// ----- hw/rtl/ifg_pkg.sv -----
// Shared types and constants for the inference frame gate.
// No dependencies; every other file of the block imports this package.
package ifg_pkg;

    // Q1.15 confidence values reported with a decision.
    localparam logic [15:0] Q_ONE    = 16'd32768;
    localparam logic [15:0] Q_HALF   = 16'd16384;
    localparam logic [15:0] Q_POINT3 = 16'd9830;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONF_THR    = 2'd0;
    localparam logic [1:0] CFG_FRAME_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TIME_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_CRACK_THR   = 2'd3;

    // Configuration register reset values.
    localparam logic [15:0] RST_CONF_THR    = 16'd22938;
    localparam logic [15:0] RST_FRAME_LIMIT = 16'd10;
    localparam logic [31:0] RST_TIME_LIMIT  = 32'd500000;
    localparam logic [15:0] RST_CRACK_THR   = 16'd26214;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Decision reason codes, in priority order.
    typedef enum logic [2:0] {
        REASON_FORCED  = 3'd0,
        REASON_CRACK   = 3'd1,
        REASON_FRAMES  = 3'd2,
        REASON_TIME    = 3'd3,
        REASON_NOVEL   = 3'd4,
        REASON_LOWCONF = 3'd5,
        REASON_SKIP    = 3'd6
    } t_reason;

    // Current configuration.
    typedef struct packed {
        logic [15:0] conf_thr;
        logic [15:0] frame_limit;
        logic [31:0] time_limit;
        logic [15:0] crack_thr;
    } t_cfg;

    // Stateless classification of one frame, made by the front.
    typedef struct packed {
        logic        force_run;
        logic        crack_hit;
        logic        matched;
        logic        low_conf;
        logic [15:0] sconf;
    } t_class;

endpackage

// ----- hw/rtl/ifg_cfg.sv -----
// Configuration registers of the inference frame gate.
// Depends on ifg_pkg for the register indexes, reset values and t_cfg.
module ifg_cfg
    import ifg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a write into the addressed register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONF_THR:    n_cfg.conf_thr    = i_cfg_data[15:0];
                CFG_FRAME_LIMIT: n_cfg.frame_limit = i_cfg_data[15:0];
                CFG_TIME_LIMIT:  n_cfg.time_limit  = i_cfg_data;
                CFG_CRACK_THR:   n_cfg.crack_thr   = i_cfg_data[15:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_thr    <= RST_CONF_THR;
            r_cfg.frame_limit <= RST_FRAME_LIMIT;
            r_cfg.time_limit  <= RST_TIME_LIMIT;
            r_cfg.crack_thr   <= RST_CRACK_THR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/ifg_front.sv -----
// Front of the inference frame gate: accepts frame words and classifies them.
// Depends on ifg_pkg for t_cfg and t_class.
module ifg_front
    import ifg_pkg::*;
#(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_signature_matched,
    input  logic [15:0]           i_signature_confidence,
    input  logic [15:0]           i_crack_level,
    input  logic                  i_force_run,
    input  logic [TIME_WIDTH-1:0] i_current_time,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_class                o_class,
    output logic [TIME_WIDTH-1:0] o_time
);

    logic                  r_valid;
    t_class                r_class;
    logic [TIME_WIDTH-1:0] r_time;
    t_class                n_class;
    logic                  accept;

    // The held word moves on whenever the queue has room.
    assign o_push  = r_valid && !i_queue_full;
    assign o_stall = r_valid && i_queue_full;
    assign accept  = i_valid && !o_stall;

    // Compares that need no state of the gate.
    always_comb begin
        n_class.force_run = i_force_run;
        n_class.crack_hit = (i_crack_level >= i_cfg.crack_thr);
        n_class.matched   = i_signature_matched;
        n_class.low_conf  = (i_signature_confidence < i_cfg.conf_thr);
        n_class.sconf     = i_signature_confidence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_class <= n_class;
            r_time  <= i_current_time;
        end
    end

    assign o_class = r_class;
    assign o_time  = r_time;

endmodule

// ----- hw/rtl/ifg_queue.sv -----
// Short first-in first-out queue between the front and the back.
// Depends on ifg_pkg for the queue depth.
module ifg_queue
    import ifg_pkg::*;
#(
    parameter int DATA_WIDTH = 68
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/ifg_back.sv -----
// Back of the inference frame gate: makes the decision, keeps the gate state
// and statistics, and holds the result word. Depends on ifg_pkg.
module ifg_back
    import ifg_pkg::*;
#(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_queue_empty,
    output logic                  o_pop,
    input  t_class                i_class,
    input  logic [TIME_WIDTH-1:0] i_time,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_do_infer,
    output logic [15:0]           o_decision_confidence,
    output logic [2:0]            o_decision_reason,
    output logic                  o_echo_matched,
    output logic [15:0]           o_echo_confidence,
    output logic [15:0]           o_frames_since_last,
    output logic [31:0]           o_time_since_last,
    output logic [31:0]           o_decision_count,
    output logic [31:0]           o_inferred_total,
    output logic [31:0]           o_skipped_total,
    output logic [31:0]           o_current_streak,
    output logic [31:0]           o_longest_streak
);

    localparam logic [TIME_WIDTH-1:0]  DT_SAT  = TIME_WIDTH'(64'h0000_0000_FFFF_FFFF);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Gate state.
    logic [15:0]            r_frame_cnt;
    logic [TIME_WIDTH-1:0]  r_stamp;
    logic [COUNT_WIDTH-1:0] r_run;
    logic [COUNT_WIDTH-1:0] r_peak;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] r_infers;
    logic [COUNT_WIDTH-1:0] r_skips;

    // Result word.
    logic        r_out_valid;
    logic        r_infer;
    logic [15:0] r_dconf;
    t_reason     r_reason;
    logic        r_matched;
    logic [15:0] r_sconf;
    logic [15:0] r_frames;
    logic [31:0] r_dt;

    logic [TIME_WIDTH-1:0]  diff;
    logic [32:0]            dt_none;
    logic [31:0]            n_dt;
    logic [15:0]            n_frames;
    logic                   n_infer;
    logic [15:0]            n_dconf;
    t_reason                n_reason;
    logic [COUNT_WIDTH-1:0] n_run;

    // Take a word when the result register is free or being taken.
    assign o_pop = !i_queue_empty && (!r_out_valid || !i_stall);

    // Time since the last inference, clamped to 32 bits; with a zero stamp, the time limit plus one.
    always_comb begin
        diff    = (i_time >= r_stamp) ? (i_time - r_stamp) : '0;
        dt_none = {1'b0, i_cfg.time_limit} + 33'd1;
        if (r_stamp != '0) begin
            n_dt = (diff > DT_SAT) ? 32'hFFFF_FFFF : diff[31:0];
        end else begin
            n_dt = dt_none[32] ? 32'hFFFF_FFFF : dt_none[31:0];
        end
    end

    // Frame count including this frame, then the priority cascade.
    always_comb begin
        n_frames = (r_frame_cnt == 16'hFFFF) ? r_frame_cnt : r_frame_cnt + 16'd1;
        n_infer  = 1'b1;
        if (i_class.force_run) begin
            n_dconf  = Q_ONE;
            n_reason = REASON_FORCED;
        end else if (i_class.crack_hit) begin
            n_dconf  = Q_ONE;
            n_reason = REASON_CRACK;
        end else if (n_frames >= i_cfg.frame_limit) begin
            n_dconf  = Q_HALF;
            n_reason = REASON_FRAMES;
        end else if (n_dt >= i_cfg.time_limit) begin
            n_dconf  = Q_HALF;
            n_reason = REASON_TIME;
        end else if (!i_class.matched) begin
            n_dconf  = Q_POINT3;
            n_reason = REASON_NOVEL;
        end else if (i_class.low_conf) begin
            n_dconf  = i_class.sconf;
            n_reason = REASON_LOWCONF;
        end else begin
            n_dconf  = i_class.sconf;
            n_reason = REASON_SKIP;
            n_infer  = 1'b0;
        end
        n_run = (r_run == CNT_MAX) ? r_run : r_run + 1'b1;
    end

    // State and statistics update on each decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt <= '0;
            r_stamp     <= '0;
            r_run       <= '0;
            r_peak      <= '0;
            r_total     <= '0;
            r_infers    <= '0;
            r_skips     <= '0;
        end else if (o_pop) begin
            if (r_total != CNT_MAX) begin
                r_total <= r_total + 1'b1;
            end
            if (n_infer) begin
                r_frame_cnt <= '0;
                r_stamp     <= i_time;
                r_run       <= '0;
                if (r_infers != CNT_MAX) begin
                    r_infers <= r_infers + 1'b1;
                end
            end else begin
                r_frame_cnt <= n_frames;
                r_run       <= n_run;
                if (n_run > r_peak) begin
                    r_peak <= n_run;
                end
                if (r_skips != CNT_MAX) begin
                    r_skips <= r_skips + 1'b1;
                end
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_infer   <= n_infer;
            r_dconf   <= n_dconf;
            r_reason  <= n_reason;
            r_matched <= i_class.matched;
            r_sconf   <= i_class.sconf;
            r_frames  <= n_frames;
            r_dt      <= n_dt;
        end
    end

    // The statistics registers change only with a new result, so they
    // are shown directly as part of the result word.
    assign o_valid               = r_out_valid;
    assign o_do_infer            = r_infer;
    assign o_decision_confidence = r_dconf;
    assign o_decision_reason     = r_reason;
    assign o_echo_matched        = r_matched;
    assign o_echo_confidence     = r_sconf;
    assign o_frames_since_last   = r_frames;
    assign o_time_since_last     = r_dt;
    assign o_decision_count      = 32'(r_total);
    assign o_inferred_total      = 32'(r_infers);
    assign o_skipped_total       = 32'(r_skips);
    assign o_current_streak      = 32'(r_run);
    assign o_longest_streak      = 32'(r_peak);

endmodule

// ----- hw/rtl/inference_frame_gate.sv -----
// Top level of the inference frame gate: configuration, front, queue, back.
// Depends on ifg_pkg, ifg_cfg, ifg_front, ifg_queue and ifg_back.
//
//   Port group   Direction   Handshake            Contents
//   frame in     input       i_valid / o_stall    match, confidence, crack, force, time
//   decision     output      o_valid / i_stall    decision, reason, statistics
//   config       input       i_cfg_we             index and 32-bit data, no wait
//
// A word passes the front register, the queue and the back result register;
// one word per cycle is sustained while the result is not stalled.
// The back decides one word per cycle while its result is not stalled, as the
// frame count and the last inference time feed straight back into the next decision.
// Reset is synchronous, active low; it clears all counters and loads the
// register defaults. A stalled result stays held while the front and the
// two-entry queue keep taking words until the queue fills.
module inference_frame_gate
    import ifg_pkg::*;
#(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_signature_matched,
    input  logic [15:0]           i_signature_confidence,
    input  logic [15:0]           i_crack_level,
    input  logic                  i_force_run,
    input  logic [TIME_WIDTH-1:0] i_current_time,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_do_infer,
    output logic [15:0]           o_decision_confidence,
    output logic [2:0]            o_decision_reason,
    output logic                  o_echo_matched,
    output logic [15:0]           o_echo_confidence,
    output logic [15:0]           o_frames_since_last,
    output logic [31:0]           o_time_since_last,
    output logic [31:0]           o_decision_count,
    output logic [31:0]           o_inferred_total,
    output logic [31:0]           o_skipped_total,
    output logic [31:0]           o_current_streak,
    output logic [31:0]           o_longest_streak
);

    localparam int Q_WIDTH = $bits(t_class) + TIME_WIDTH;

    t_cfg                  cfg;
    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    t_class                front_class;
    logic [TIME_WIDTH-1:0] front_time;
    logic [Q_WIDTH-1:0]    q_out;
    t_class                back_class;
    logic [TIME_WIDTH-1:0] back_time;

    ifg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ifg_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg                  (cfg),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_signature_matched    (i_signature_matched),
        .i_signature_confidence (i_signature_confidence),
        .i_crack_level          (i_crack_level),
        .i_force_run            (i_force_run),
        .i_current_time         (i_current_time),
        .i_queue_full           (q_full),
        .o_push                 (push),
        .o_class                (front_class),
        .o_time                 (front_time)
    );

    ifg_queue #(
        .DATA_WIDTH (Q_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_class, front_time}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign back_class = q_out[Q_WIDTH-1:TIME_WIDTH];
    assign back_time  = q_out[TIME_WIDTH-1:0];

    ifg_back #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (cfg),
        .i_queue_empty         (q_empty),
        .o_pop                 (pop),
        .i_class               (back_class),
        .i_time                (back_time),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_do_infer            (o_do_infer),
        .o_decision_confidence (o_decision_confidence),
        .o_decision_reason     (o_decision_reason),
        .o_echo_matched        (o_echo_matched),
        .o_echo_confidence     (o_echo_confidence),
        .o_frames_since_last   (o_frames_since_last),
        .o_time_since_last     (o_time_since_last),
        .o_decision_count      (o_decision_count),
        .o_inferred_total      (o_inferred_total),
        .o_skipped_total       (o_skipped_total),
        .o_current_streak      (o_current_streak),
        .o_longest_streak      (o_longest_streak)
    );

endmodule

// ----- tb/ifg_checker.sv -----
// Checker for the inference frame gate: watches the frame, decision and register ports.
// It predicts every decision word from its own copy of the gate state and compares.
// Depends on ifg_pkg for the register indexes, reset values, reason codes and Q1.15 values.
module ifg_checker
    import ifg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_frame_valid,
    input  logic        i_frame_stall,
    input  logic        i_signature_matched,
    input  logic [15:0] i_signature_confidence,
    input  logic [15:0] i_crack_level,
    input  logic        i_force_run,
    input  logic [47:0] i_current_time,
    input  logic        i_result_valid,
    input  logic        i_result_stall,
    input  logic        i_do_infer,
    input  logic [15:0] i_decision_confidence,
    input  logic [2:0]  i_decision_reason,
    input  logic        i_echo_matched,
    input  logic [15:0] i_echo_confidence,
    input  logic [15:0] i_frames_since_last,
    input  logic [31:0] i_time_since_last,
    input  logic [31:0] i_decision_count,
    input  logic [31:0] i_inferred_total,
    input  logic [31:0] i_skipped_total,
    input  logic [31:0] i_current_streak,
    input  logic [31:0] i_longest_streak,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_infers,
    output logic [31:0] o_peak_run,
    output logic [6:0]  o_reason_seen
);

    // One decision word as the gate should report it.
    typedef struct packed {
        logic        infer;
        logic [15:0] conf;
        logic [2:0]  reason;
        logic        matched;
        logic [15:0] sconf;
        logic [15:0] frames;
        logic [31:0] elapsed;
        logic [31:0] total;
        logic [31:0] infers;
        logic [31:0] skips;
        logic [31:0] streak;
        logic [31:0] peak;
    } t_gate_verdict;

    // Shadow copy of the registers.
    logic [15:0] conf_thr;
    logic [15:0] frame_limit;
    logic [31:0] time_limit;
    logic [15:0] crack_thr;

    // Shadow copy of the gate state.
    logic [15:0] frame_count;
    logic [47:0] last_stamp;
    logic [31:0] skip_run;
    logic [31:0] skip_peak;
    logic [31:0] decision_total;
    logic [31:0] infer_total;
    logic [31:0] skip_total;

    t_gate_verdict awaited_verdicts[$];
    int            mismatches;
    int            checked;
    int            infers_seen;
    logic [6:0]    reasons_seen;

    assign o_fail_count  = mismatches;
    assign o_pending     = awaited_verdicts.size();
    assign o_checked     = checked;
    assign o_infers      = infers_seen;
    assign o_peak_run    = skip_peak;
    assign o_reason_seen = reasons_seen;

    function automatic logic [31:0] bump32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Runs one frame through the priority cascade and advances the shadow state.
    function automatic t_gate_verdict decide_frame(input logic matched, input logic [15:0] sconf,
                                                   input logic [15:0] crack,
                                                   input logic force_in, input logic [47:0] now);
        t_gate_verdict v;
        logic [63:0]   span;
        v = '0;
        if (last_stamp != 48'd0) begin
            span = (now >= last_stamp) ? 64'(now) - 64'(last_stamp) : 64'd0;
        end else begin
            span = 64'(time_limit) + 64'd1;
        end
        if (span > 64'hFFFF_FFFF) begin
            span = 64'hFFFF_FFFF;
        end
        if (frame_count != 16'hFFFF) begin
            frame_count = frame_count + 16'd1;
        end

        v.infer = 1'b1;
        if (force_in) begin
            v.conf = Q_ONE;
            v.reason = REASON_FORCED;
        end else if (crack >= crack_thr) begin
            v.conf = Q_ONE;
            v.reason = REASON_CRACK;
        end else if (frame_count >= frame_limit) begin
            v.conf = Q_HALF;
            v.reason = REASON_FRAMES;
        end else if (span >= 64'(time_limit)) begin
            v.conf = Q_HALF;
            v.reason = REASON_TIME;
        end else if (!matched) begin
            v.conf = Q_POINT3;
            v.reason = REASON_NOVEL;
        end else if (sconf < conf_thr) begin
            v.conf = sconf;
            v.reason = REASON_LOWCONF;
        end else begin
            v.conf = sconf;
            v.reason = REASON_SKIP;
            v.infer = 1'b0;
        end
        v.matched = matched;
        v.sconf = sconf;
        v.frames = frame_count;
        v.elapsed = span[31:0];

        // An inference restarts the frame count and the streak; a skip extends the streak.
        decision_total = bump32(decision_total);
        if (v.infer) begin
            frame_count = 16'd0;
            last_stamp = now;
            skip_run = 32'd0;
            infer_total = bump32(infer_total);
        end else begin
            skip_run = bump32(skip_run);
            if (skip_run > skip_peak) begin
                skip_peak = skip_run;
            end
            skip_total = bump32(skip_total);
        end
        v.total = decision_total;
        v.infers = infer_total;
        v.skips = skip_total;
        v.streak = skip_run;
        v.peak = skip_peak;
        return v;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in decision %0d, %s: expected %0d, got %0d",
                     checked, field, want, got);
        end
    endtask

    // Sample both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        t_gate_verdict want;
        t_gate_verdict got;
        if (!i_rst_n) begin
            conf_thr = RST_CONF_THR;
            frame_limit = RST_FRAME_LIMIT;
            time_limit = RST_TIME_LIMIT;
            crack_thr = RST_CRACK_THR;
            frame_count = '0;
            last_stamp = '0;
            skip_run = '0;
            skip_peak = '0;
            decision_total = '0;
            infer_total = '0;
            skip_total = '0;
            awaited_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CONF_THR:    conf_thr = i_cfg_data[15:0];
                    CFG_FRAME_LIMIT: frame_limit = i_cfg_data[15:0];
                    CFG_TIME_LIMIT:  time_limit = i_cfg_data;
                    CFG_CRACK_THR:   crack_thr = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // Compare a delivered decision word against the oldest prediction.
            if (i_result_valid && !i_result_stall) begin
                got = {i_do_infer, i_decision_confidence, i_decision_reason,
                       i_echo_matched, i_echo_confidence, i_frames_since_last,
                       i_time_since_last, i_decision_count, i_inferred_total,
                       i_skipped_total, i_current_streak, i_longest_streak};
                if (awaited_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Decision word delivered with no frame waiting for it");
                    end
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.infer !== want.infer)
                        flag_mismatch("do_infer", 64'(want.infer), 64'(got.infer));
                    if (got.conf !== want.conf)
                        flag_mismatch("decision_confidence", 64'(want.conf), 64'(got.conf));
                    if (got.reason !== want.reason)
                        flag_mismatch("decision_reason", 64'(want.reason), 64'(got.reason));
                    if (got.matched !== want.matched)
                        flag_mismatch("echo_matched", 64'(want.matched), 64'(got.matched));
                    if (got.sconf !== want.sconf)
                        flag_mismatch("echo_confidence", 64'(want.sconf), 64'(got.sconf));
                    if (got.frames !== want.frames)
                        flag_mismatch("frames_since_last", 64'(want.frames), 64'(got.frames));
                    if (got.elapsed !== want.elapsed)
                        flag_mismatch("time_since_last", 64'(want.elapsed),
                                      64'(got.elapsed));
                    if (got.total !== want.total)
                        flag_mismatch("decision_count", 64'(want.total), 64'(got.total));
                    if (got.infers !== want.infers)
                        flag_mismatch("inferred_total", 64'(want.infers), 64'(got.infers));
                    if (got.skips !== want.skips)
                        flag_mismatch("skipped_total", 64'(want.skips), 64'(got.skips));
                    if (got.streak !== want.streak)
                        flag_mismatch("current_streak", 64'(want.streak), 64'(got.streak));
                    if (got.peak !== want.peak)
                        flag_mismatch("longest_streak", 64'(want.peak), 64'(got.peak));
                    reasons_seen[want.reason] = 1'b1;
                    if (want.infer) begin
                        infers_seen++;
                    end
                end
                checked++;
            end

            // Predict the decision for an accepted frame word.
            if (i_frame_valid && !i_frame_stall) begin
                awaited_verdicts.push_back(decide_frame(i_signature_matched,
                                                        i_signature_confidence, i_crack_level,
                                                        i_force_run, i_current_time));
            end
        end
    end

    initial begin
        mismatches = 0;
        checked = 0;
        infers_seen = 0;
        reasons_seen = '0;
    end

endmodule

// ----- tb/tb_inference_frame_gate.sv -----
// Testbench top for the inference frame gate: clock, reset, frame and register stimulus.
// Depends on ifg_pkg, inference_frame_gate and ifg_checker, which does all the checking.
// Directed frames walk the priority cascade, then random frames run under several settings.
module tb_inference_frame_gate;
    import ifg_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_FRAMES  = 280;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct {
        logic        matched;
        logic [15:0] conf;
        logic [15:0] crack;
        logic        force_in;
        logic [47:0] when_us;
    } t_frame;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        frame_valid;
    logic        frame_stall;
    logic        sig_matched;
    logic [15:0] sig_conf;
    logic [15:0] crack_level;
    logic        force_run;
    logic [47:0] frame_time;
    logic        result_valid;
    logic        result_stall;
    logic        do_infer;
    logic [15:0] decision_conf;
    logic [2:0]  decision_reason;
    logic        echo_matched;
    logic [15:0] echo_conf;
    logic [15:0] frames_since_last;
    logic [31:0] time_since_last;
    logic [31:0] decision_count;
    logic [31:0] inferred_total;
    logic [31:0] skipped_total;
    logic [31:0] current_streak;
    logic [31:0] longest_streak;

    int          fail_count;
    int          pending;
    int          checked;
    int          infers;
    logic [31:0] peak_run;
    logic [6:0]  reason_seen;

    // Settings currently loaded, used to aim random frames at the thresholds.
    logic [15:0] knob_conf_thr;
    logic [31:0] knob_time_limit;
    logic [15:0] knob_crack_thr;
    logic [47:0] frame_clock;
    int          settings_used;
    int          cycle_count;
    bit          hold_request;

    inference_frame_gate i_dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_valid                (frame_valid),
        .o_stall                (frame_stall),
        .i_signature_matched    (sig_matched),
        .i_signature_confidence (sig_conf),
        .i_crack_level          (crack_level),
        .i_force_run            (force_run),
        .i_current_time         (frame_time),
        .o_valid                (result_valid),
        .i_stall                (result_stall),
        .o_do_infer             (do_infer),
        .o_decision_confidence  (decision_conf),
        .o_decision_reason      (decision_reason),
        .o_echo_matched         (echo_matched),
        .o_echo_confidence      (echo_conf),
        .o_frames_since_last    (frames_since_last),
        .o_time_since_last      (time_since_last),
        .o_decision_count       (decision_count),
        .o_inferred_total       (inferred_total),
        .o_skipped_total        (skipped_total),
        .o_current_streak       (current_streak),
        .o_longest_streak       (longest_streak)
    );

    ifg_checker i_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_frame_valid          (frame_valid),
        .i_frame_stall          (frame_stall),
        .i_signature_matched    (sig_matched),
        .i_signature_confidence (sig_conf),
        .i_crack_level          (crack_level),
        .i_force_run            (force_run),
        .i_current_time         (frame_time),
        .i_result_valid         (result_valid),
        .i_result_stall         (result_stall),
        .i_do_infer             (do_infer),
        .i_decision_confidence  (decision_conf),
        .i_decision_reason      (decision_reason),
        .i_echo_matched         (echo_matched),
        .i_echo_confidence      (echo_conf),
        .i_frames_since_last    (frames_since_last),
        .i_time_since_last      (time_since_last),
        .i_decision_count       (decision_count),
        .i_inferred_total       (inferred_total),
        .i_skipped_total        (skipped_total),
        .i_current_streak       (current_streak),
        .i_longest_streak       (longest_streak),
        .o_fail_count           (fail_count),
        .o_pending              (pending),
        .o_checked              (checked),
        .o_infers               (infers),
        .o_peak_run             (peak_run),
        .o_reason_seen          (reason_seen)
    );

    // Free-running clock, period 10.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run exceeded %0d cycles, %0d decisions still outstanding",
                 CYCLE_LIMIT, pending);
        $display("tb_inference_frame_gate NOT OK");
        $finish;
    end

    // Receiver: stretches of free flow, light and heavy stalling, and a fixed
    // stall pattern; a long hold-off is taken whenever the sender asks for one.
    initial begin
        int mode;
        int stretch;
        result_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            for (int k = 0; k < stretch; k++) begin
                @(negedge clk);
                if (hold_request) begin
                    hold_request = 1'b0;
                    result_stall = 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end else begin
                    case (mode)
                        0: result_stall = 1'b0;
                        1: result_stall = ($urandom_range(0, 3) == 0);
                        2: result_stall = ($urandom_range(0, 3) != 0);
                        default: result_stall = ((k % 5) < 2);
                    endcase
                end
            end
        end
    end

    function automatic t_frame frame_of(input logic matched, input logic [15:0] conf,
                                        input logic [15:0] crack, input logic force_in,
                                        input logic [47:0] when_us);
        t_frame f;
        f.matched = matched;
        f.conf = conf;
        f.crack = crack;
        f.force_in = force_in;
        f.when_us = when_us;
        return f;
    endfunction

    // Offers one frame word and returns once the gate has taken it.
    task automatic send_frame(input t_frame f);
        @(negedge clk);
        frame_valid = 1'b1;
        sig_matched = f.matched;
        sig_conf = f.conf;
        crack_level = f.crack;
        force_run = f.force_in;
        frame_time = f.when_us;
        @(posedge clk);
        while (frame_stall) @(posedge clk);
    endtask

    task automatic rest_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            frame_valid = 1'b0;
        end
    endtask

    // Sender goes quiet until every predicted decision has been delivered.
    task automatic drain_gate();
        rest_sender(1);
        while (pending != 0) @(negedge clk);
    endtask

    // Loads all four registers while the gate is idle.
    task automatic program_gate(input logic [15:0] conf_thr, input logic [15:0] frame_limit,
                                input logic [31:0] time_limit, input logic [15:0] crack_thr);
        drain_gate();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_CONF_THR;
        cfg_data = {16'd0, conf_thr};
        @(negedge clk);
        cfg_index = CFG_FRAME_LIMIT;
        cfg_data = {16'd0, frame_limit};
        @(negedge clk);
        cfg_index = CFG_TIME_LIMIT;
        cfg_data = time_limit;
        @(negedge clk);
        cfg_index = CFG_CRACK_THR;
        cfg_data = {16'd0, crack_thr};
        @(negedge clk);
        cfg_we = 1'b0;
        knob_conf_thr = conf_thr;
        knob_time_limit = time_limit;
        knob_crack_thr = crack_thr;
        settings_used++;
    endtask

    // Random frame aimed around the loaded thresholds, with a timestamp that
    // mostly moves forward a little and sometimes stalls, steps back or leaps.
    function automatic t_frame random_frame();
        t_frame      f;
        int          pick;
        logic [31:0] stride;
        logic [31:0] top;

        pick = $urandom_range(0, 99);
        top = (knob_conf_thr > 16'd32768) ? 32'd65535 : 32'd32768;
        if (pick < 55)
            f.conf = 16'($urandom_range(knob_conf_thr, top));
        else if (pick < 70)
            f.conf = (knob_conf_thr == 0) ? 16'd0 : 16'($urandom_range(0, knob_conf_thr - 1));
        else if (pick < 85)
            f.conf = knob_conf_thr + 16'($urandom_range(0, 2)) - 16'd1;
        else
            f.conf = 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 75)
            f.crack = (knob_crack_thr == 0) ? 16'd0 : 16'($urandom_range(0, knob_crack_thr - 1));
        else if (pick < 85)
            f.crack = knob_crack_thr + 16'($urandom_range(0, 2)) - 16'd1;
        else
            f.crack = 16'($urandom);

        f.matched = ($urandom_range(0, 99) < 85);
        f.force_in = ($urandom_range(0, 99) < 4);

        stride = (knob_time_limit < 32'd6) ? 32'd1 : knob_time_limit / 6;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            frame_clock = frame_clock + 48'($urandom_range(1, stride));
        else if (pick < 68)
            frame_clock = frame_clock;
        else if (pick < 76)
            frame_clock = frame_clock - 48'($urandom_range(1, 1000));
        else if (pick < 86)
            frame_clock = frame_clock + 48'(knob_time_limit) + 48'($urandom_range(0, 2)) - 48'd1;
        else if (pick < 92)
            frame_clock = frame_clock + {16'($urandom_range(1, 65535)), 32'd0};
        else if (pick < 93)
            frame_clock = 48'd0;
        else
            frame_clock = {16'($urandom), 32'($urandom)};
        f.when_us = frame_clock;
        return f;
    endfunction

    // Bursts of random frames with random gaps; an optional long receiver
    // hold-off at the start and an optional full drain halfway through.
    task automatic run_phase(input int frames, input bit with_hold, input bit with_drain);
        int sent;
        int burst;
        sent = 0;
        if (with_hold) begin
            hold_request = 1'b1;
            for (int k = 0; k < 40; k++) begin
                send_frame(random_frame());
                sent++;
            end
            rest_sender(1);
        end
        while (sent < frames) begin
            burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < frames; k++) begin
                send_frame(random_frame());
                sent++;
                if (with_drain && sent == frames / 2) begin
                    drain_gate();
                end
            end
            rest_sender($urandom_range(1, 6));
        end
    endtask

    // Main stimulus.
    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CONF_THR;
        cfg_data = '0;
        frame_valid = 1'b0;
        sig_matched = 1'b0;
        sig_conf = '0;
        crack_level = '0;
        force_run = 1'b0;
        frame_time = '0;
        hold_request = 1'b0;
        settings_used = 1;
        frame_clock = '0;
        knob_conf_thr = RST_CONF_THR;
        knob_time_limit = RST_TIME_LIMIT;
        knob_crack_thr = RST_CRACK_THR;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk through the cascade under the reset settings.
        // First frame at time zero: with no inference yet it infers on the time limit, and the stamp stays zero.
        send_frame(frame_of(1'b1, 16'd30000, 16'd0, 1'b0, 48'd0));
        send_frame(frame_of(1'b1, 16'd30000, 16'd0, 1'b0, 48'd50));
        send_frame(frame_of(1'b1, 16'd30000, 16'd0, 1'b0, 48'd150));
        send_frame(frame_of(1'b1, 16'd22938, 16'd0, 1'b0, 48'd200));
        send_frame(frame_of(1'b1, 16'd22937, 16'd0, 1'b0, 48'd250));
        send_frame(frame_of(1'b0, 16'd30000, 16'd0, 1'b0, 48'd300));
        send_frame(frame_of(1'b1, 16'd30000, 16'd26214, 1'b0, 48'd350));
        send_frame(frame_of(1'b1, 16'd30000, 16'd26213, 1'b0, 48'd400));
        send_frame(frame_of(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 48'd450));
        // Time going backwards reads as zero elapsed.
        send_frame(frame_of(1'b1, 16'd0, 16'd0, 1'b0, 48'd300));
        // Nine skips, then the frame limit fires on the tenth frame.
        for (int k = 0; k < 10; k++) begin
            send_frame(frame_of(1'b1, (k == 0) ? 16'hFFFF : 16'd32768, 16'd0, 1'b0,
                                48'd310 + 48'(k * 10)));
        end
        // A huge jump saturates the elapsed time, then the largest timestamp.
        send_frame(frame_of(1'b1, 16'd32768, 16'd0, 1'b0, 48'd300 + (48'd1 << 40)));
        send_frame(frame_of(1'b1, 16'd32768, 16'd0, 1'b0, 48'hFFFF_FFFF_FFFF));
        send_frame(frame_of(1'b1, 16'd32768, 16'd0, 1'b0, 48'hFFFF_FFFF_FFFF));
        frame_clock = 48'd1000;

        // Random phases under a range of settings.
        run_phase(PHASE_FRAMES, 1'b0, 1'b0);
        program_gate(16'd0, 16'd65535, 32'hFFFF_FFFF, 16'd32768);
        run_phase(PHASE_FRAMES, 1'b1, 1'b0);
        program_gate(16'd32768, 16'd1, 32'd1, 16'd0);
        run_phase(PHASE_FRAMES, 1'b0, 1'b1);
        // Raw out-of-range values, including a zero frame limit.
        program_gate(16'hFFFF, 16'd0, 32'd0, 16'hFFFF);
        run_phase(PHASE_FRAMES, 1'b0, 1'b0);
        for (int p = 0; p < 2; p++) begin
            program_gate(16'($urandom_range(0, 32768)), 16'($urandom_range(1, 40)),
                         32'($urandom_range(1, 2000000)), 16'($urandom_range(0, 32768)));
            run_phase(PHASE_FRAMES, p == 1, 1'b0);
        end
        program_gate(RST_CONF_THR, RST_FRAME_LIMIT, RST_TIME_LIMIT, RST_CRACK_THR);
        run_phase(PHASE_FRAMES, 1'b0, 1'b0);

        // Let the pipeline settle and catch any stray decision words.
        drain_gate();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d decisions under %0d register settings: %0d inferred, %0d skipped",
                 checked, settings_used, infers, checked - infers);
        $display("Reason codes delivered (one bit per code): %b, longest skip run %0d",
                 reason_seen, peak_run);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_inference_frame_gate OK");
        end else begin
            $display("tb_inference_frame_gate NOT OK");
        end
        $finish;
    end

endmodule

// ----- inference_frame_gate.f -----
hw/rtl/ifg_pkg.sv
hw/rtl/ifg_cfg.sv
hw/rtl/ifg_front.sv
hw/rtl/ifg_queue.sv
hw/rtl/ifg_back.sv
hw/rtl/inference_frame_gate.sv
tb/ifg_checker.sv
tb/tb_inference_frame_gate.sv
